// ===== hw/rtl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern search block.
package wbps_pkg;

    // Window and pattern geometry
    localparam int MAX_PATTERN   = 32;
    localparam int BYTE_BITS     = 8;
    localparam int WORD_BITS     = 64;
    localparam int PATTERN_WORDS = MAX_PATTERN * BYTE_BITS / WORD_BITS;
    localparam int LEN_BITS      = 6;
    localparam int CELL_IDX_BITS = $clog2(MAX_PATTERN);
    localparam int OFFSET_BITS   = 32;
    localparam int CFG_IDX_BITS  = 3;

    // Byte value that matches anything
    localparam logic [BYTE_BITS-1:0] WILDCARD = 8'h2A;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_LEN    = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4
    } t_cfg_idx;

    typedef logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] t_pattern;

    // Settings handed from the register file to the cell row
    typedef struct packed {
        t_pattern              pattern;
        logic [LEN_BITS-1:0]   len;      // clamped to 1..MAX_PATTERN
    } t_cfg;

endpackage

// ===== hw/rtl/wildcard_byte_pattern_search_top.sv =====
// Top level of the wildcard byte pattern search block.
// Streams one section's bytes in (tlast marks the final byte) and returns at most one
// result per section: tuser=1 with the offset of the first match start, or tuser=0 with
// offset 0 when the section ends without a match (also when it is shorter than the
// pattern). A pattern byte of 0x2A matches any byte. One byte is taken every cycle while
// input ready is high. The row of 32 window cells registers the byte at the accept, and
// the decision stage compares all cells in parallel into the output register once that
// register can advance. Input ready drops only while the decision stage holds an item
// and the output register is stalled.
// Configuration writes are taken at any time but are meant for idle periods between items.
module wildcard_byte_pattern_search_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] data_byte
    input  logic                              i_s_tlast,   // last_byte
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [wbps_pkg::OFFSET_BITS-1:0]  o_m_tdata,   // [31:0] match_offset
    output logic                              o_m_tuser,   // [0] found
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [wbps_pkg::WORD_BITS-1:0]    i_cfg_data
);

    wbps_pkg::t_cfg                                        w_cfg;
    logic [wbps_pkg::MAX_PATTERN:0][wbps_pkg::BYTE_BITS-1:0] w_chain;
    logic [wbps_pkg::MAX_PATTERN-1:0]                      w_hits;
    logic                                                  w_take;
    logic                                                  w_hold;
    logic [wbps_pkg::OFFSET_BITS-1:0]                      r_count;
    logic [wbps_pkg::OFFSET_BITS-1:0]                      n_count;

    wbps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_s_tready = !w_hold;
    assign w_take     = i_s_tvalid && o_s_tready;

    // Row of window cells, newest byte enters at cell 0
    assign w_chain[0] = i_s_tdata;

    for (genvar k = 0; k < wbps_pkg::MAX_PATTERN; k++) begin : g_cell
        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_take),
            .i_index (wbps_pkg::CELL_IDX_BITS'(k)),
            .i_byte  (w_chain[k]),
            .i_cfg   (w_cfg),
            .o_byte  (w_chain[k+1]),
            .o_hit   (w_hits[k])
        );
    end

    // Count bytes of the section, saturate, restart after the last byte
    assign n_count = (&r_count) ? r_count : (r_count + wbps_pkg::OFFSET_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_take) begin
            r_count <= i_s_tlast ? '0 : n_count;
        end
    end

    wbps_report u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_last      (i_s_tlast),
        .i_count     (n_count),
        .i_match     (&w_hits),
        .i_len       (w_cfg.len),
        .o_busy_hold (w_hold),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_found     (o_m_tuser),
        .o_offset    (o_m_tdata)
    );

    // A not-found result always carries offset zero
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("not-found result with nonzero offset");

    // Input stalls only behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // Effective pattern length stays within the window
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg.len != '0) && (w_cfg.len <= wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN)))
        else $error("pattern length out of range");

    // A found offset is never the all-ones value
    a_offset_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata <= ~wbps_pkg::OFFSET_BITS'(0) - wbps_pkg::OFFSET_BITS'(1)))
        else $error("match offset out of range");

endmodule

// ===== hw/rtl/wbps_cfg_regs.sv =====
// Configuration register file: pattern length and pattern bytes.
module wbps_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [wbps_pkg::WORD_BITS-1:0]    i_cfg_data,
    output wbps_pkg::t_cfg                    o_cfg
);

    logic [wbps_pkg::LEN_BITS-1:0]                                  r_len;
    logic [wbps_pkg::PATTERN_WORDS-1:0][wbps_pkg::WORD_BITS-1:0]   r_words;

    assign o_cfg_ready = 1'b1;

    // Take a write transaction; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= wbps_pkg::LEN_BITS'(1);
            r_words <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wbps_pkg::CFG_PATTERN_LEN:    r_len      <= i_cfg_data[wbps_pkg::LEN_BITS-1:0];
                wbps_pkg::CFG_PATTERN_WORD_0: r_words[0] <= i_cfg_data;
                wbps_pkg::CFG_PATTERN_WORD_1: r_words[1] <= i_cfg_data;
                wbps_pkg::CFG_PATTERN_WORD_2: r_words[2] <= i_cfg_data;
                wbps_pkg::CFG_PATTERN_WORD_3: r_words[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the length: zero acts as one, anything above the window as full
    always_comb begin
        o_cfg.pattern = wbps_pkg::t_pattern'(r_words);
        if (r_len == '0) begin
            o_cfg.len = wbps_pkg::LEN_BITS'(1);
        end else if (r_len > wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN)) begin
            o_cfg.len = wbps_pkg::LEN_BITS'(wbps_pkg::MAX_PATTERN);
        end else begin
            o_cfg.len = r_len;
        end
    end

endmodule

// ===== hw/rtl/wbps_cell.sv =====
// One window cell: holds a byte, passes it on, and checks it against its pattern byte.
module wbps_cell (
    input  logic                               i_clk,
    input  logic                               i_shift,
    input  logic [wbps_pkg::CELL_IDX_BITS-1:0] i_index,   // age of the held byte
    input  logic [wbps_pkg::BYTE_BITS-1:0]     i_byte,    // from the younger neighbor
    input  wbps_pkg::t_cfg                     i_cfg,
    output logic [wbps_pkg::BYTE_BITS-1:0]     o_byte,    // to the older neighbor
    output logic                               o_hit
);

    logic [wbps_pkg::BYTE_BITS-1:0]     r_byte;
    logic [wbps_pkg::LEN_BITS-1:0]      w_sel_full;
    logic [wbps_pkg::CELL_IDX_BITS-1:0] w_sel;
    logic [wbps_pkg::BYTE_BITS-1:0]     w_pat;
    logic                               w_used;

    // Advance the window by one byte per accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

    // The byte of age k lines up with pattern byte len-1-k
    assign w_used     = {1'b0, i_index} < i_cfg.len;
    assign w_sel_full = i_cfg.len - wbps_pkg::LEN_BITS'(1) - {1'b0, i_index};
    assign w_sel      = w_sel_full[wbps_pkg::CELL_IDX_BITS-1:0];
    assign w_pat      = i_cfg.pattern[w_sel];

    // Cells past the pattern length never block a match
    assign o_hit = !w_used || (w_pat == wbps_pkg::WILDCARD) || (w_pat == r_byte);

endmodule

// ===== hw/rtl/wbps_report.sv =====
// Match decision stage and output register for one result per section.
module wbps_report (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,      // input transaction accepted
    input  logic                             i_last,
    input  logic [wbps_pkg::OFFSET_BITS-1:0] i_count,     // bytes seen including this one
    input  logic                             i_match,     // window equals pattern
    input  logic [wbps_pkg::LEN_BITS-1:0]    i_len,
    output logic                             o_busy_hold, // decision stage cannot move
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_found,
    output logic [wbps_pkg::OFFSET_BITS-1:0] o_offset
);

    logic                             r_s1_valid;
    logic                             r_s1_last;
    logic [wbps_pkg::OFFSET_BITS-1:0] r_s1_count;
    logic                             r_rep;
    logic                             r_out_valid;
    logic                             r_out_found;
    logic [wbps_pkg::OFFSET_BITS-1:0] r_out_offset;

    logic                             w_adv;
    logic                             w_long_enough;
    logic                             w_hit;
    logic                             w_emit;
    logic [wbps_pkg::OFFSET_BITS-1:0] w_len_ext;

    assign w_adv       = !r_out_valid || i_ready;
    assign o_busy_hold = r_s1_valid && !w_adv;

    assign w_len_ext     = {{(wbps_pkg::OFFSET_BITS-wbps_pkg::LEN_BITS){1'b0}}, i_len};
    assign w_long_enough = r_s1_count >= w_len_ext;
    assign w_hit         = !r_rep && w_long_enough && i_match;
    assign w_emit        = w_hit || (r_s1_last && !r_rep);

    // Hold the item whose window is in the cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1_last  <= i_last;
            r_s1_count <= i_count;
        end
    end

    // Track one report per section; clear at section end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= 1'b0;
        end else if (r_s1_valid && w_adv) begin
            r_rep <= r_s1_last ? 1'b0 : (r_rep || w_hit);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid && w_emit) begin
            r_out_found  <= w_hit;
            r_out_offset <= w_hit ? (r_s1_count - w_len_ext) : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_found  = r_out_found;
    assign o_offset = r_out_offset;

endmodule
